@@ rtl/etfp_pkg.sv @@
// Shared types, constants and helper functions for the escape-time fractal pixel core.
// Used by every module of the block; depends on nothing else.

package etfp_pkg;

    // Default parameter values.
    localparam int COORD_BITS_DEFAULT = 10;
    localparam int FRAC_BITS_DEFAULT  = 28;

    // Fixed datapath widths.
    localparam int Z_W       = 32;   // coordinates and Z components
    localparam int PROD_W    = 64;   // exact product of two Z_W values
    localparam int SUM_W     = 66;   // headroom for sums before saturation
    localparam int STEP_W    = 31;
    localparam int ITER_W    = 8;
    localparam int CHAN_W    = 8;
    localparam int WHEEL_W   = 10;   // bits of the integer part that steer the colour wheel
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int OUT_TDATA_W = 3 * CHAN_W;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RE_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IM_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RE_STEP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IM_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCROLL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 3'd5;

    // Register reset values.
    localparam logic signed [Z_W-1:0] RE_MIN_RST   = -32'sd536870912;
    localparam logic signed [Z_W-1:0] IM_MAX_RST   = 32'sd0;
    localparam logic [STEP_W-1:0]     STEP_RST     = '0;
    localparam logic [ITER_W-1:0]     MAX_ITER_RST = 8'd30;

    // Colour wheel segments.
    localparam logic [1:0] SEG_RED_GREEN  = 2'd0;
    localparam logic [1:0] SEG_GREEN_BLUE = 2'd1;
    localparam logic [1:0] SEG_BLUE_RED   = 2'd2;
    localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

    typedef struct packed {
        logic signed [Z_W-1:0] re_min;
        logic signed [Z_W-1:0] im_max;
        logic [STEP_W-1:0]     re_step;
        logic [STEP_W-1:0]     im_step;
        logic [STEP_W-1:0]     scroll;
        logic [ITER_W-1:0]     max_iter;
    } etfp_cfg_t;

    typedef struct packed {
        logic                  valid;
        logic signed [Z_W-1:0] zi;
    } etfp_res_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } etfp_rgb_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_CIMW,
        ST_RR,
        ST_II,
        ST_RI,
        ST_UPD,
        ST_DONE
    } etfp_state_t;

    // Clamp a wide signed sum to the signed Z_W range.
    function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
        logic hi_any;
        logic hi_all;
        begin
            hi_any = |v[SUM_W-2:Z_W-1];
            hi_all = &v[SUM_W-2:Z_W-1];
            if (!v[SUM_W-1] && hi_any)
            begin
                sat_z = {1'b0, {(Z_W-1){1'b1}}};
            end
            else if (v[SUM_W-1] && !hi_all)
            begin
                sat_z = {1'b1, {(Z_W-1){1'b0}}};
            end
            else
            begin
                sat_z = v[Z_W-1:0];
            end
        end
    endfunction

    // Colour wheel on the low bits of the integer part: three blending segments and a full-red top segment.
    function automatic etfp_rgb_t wheel(input logic [WHEEL_W-1:0] w);
        etfp_rgb_t         c;
        logic [CHAN_W-1:0] lo;
        begin
            lo = w[CHAN_W-1:0];
            case (w[WHEEL_W-1:CHAN_W])
                SEG_RED_GREEN:
                begin
                    c.red = CHAN_FULL - lo; c.green = lo; c.blue = '0;
                end
                SEG_GREEN_BLUE:
                begin
                    c.red = '0; c.green = CHAN_FULL - lo; c.blue = lo;
                end
                SEG_BLUE_RED:
                begin
                    c.red = lo; c.green = '0; c.blue = CHAN_FULL - lo;
                end
                default:
                begin
                    // Top segment: full red.
                    c.red = CHAN_FULL; c.green = '0; c.blue = '0;
                end
            endcase
            wheel = c;
        end
    endfunction

endpackage

@@ rtl/etfp_cfg_regs.sv @@
// Configuration register bank of the escape-time fractal pixel core.
// Depends on etfp_pkg for register indexes, reset values and the config struct.

module etfp_cfg_regs
    import etfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_DAT_W-1:0] cfg_wdata,
    output etfp_cfg_t            cfg
);

    etfp_cfg_t cfg_reg;
    etfp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_RE_MIN:   cfg_next.re_min   = $signed(cfg_wdata[Z_W-1:0]);
                REG_IM_MAX:   cfg_next.im_max   = $signed(cfg_wdata[Z_W-1:0]);
                REG_RE_STEP:  cfg_next.re_step  = cfg_wdata[STEP_W-1:0];
                REG_IM_STEP:  cfg_next.im_step  = cfg_wdata[STEP_W-1:0];
                REG_SCROLL:   cfg_next.scroll   = cfg_wdata[STEP_W-1:0];
                REG_MAX_ITER: cfg_next.max_iter = cfg_wdata[ITER_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.re_min   <= RE_MIN_RST;
            cfg_reg.im_max   <= IM_MAX_RST;
            cfg_reg.re_step  <= STEP_RST;
            cfg_reg.im_step  <= STEP_RST;
            cfg_reg.scroll   <= STEP_RST;
            cfg_reg.max_iter <= MAX_ITER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/etfp_mul.sv @@
// Shared signed multiplier with a registered product, used for every product of a pixel.
// Depends on etfp_pkg for the operand and product widths.

module etfp_mul
    import etfp_pkg::*;
(
    input  logic                     clk,
    input  logic signed [Z_W-1:0]    op_a,
    input  logic signed [Z_W-1:0]    op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/etfp_iter.sv @@
// Sequencer and Z datapath: forms c, then runs the escape-time loop on the shared multiplier.
// Depends on etfp_pkg and drives the operands of one etfp_mul instance.

module etfp_iter
    import etfp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  etfp_cfg_t                cfg,
    input  logic                     start,
    input  logic [COORD_BITS-1:0]    pixel_x,
    input  logic [COORD_BITS-1:0]    pixel_y,
    input  logic                     res_ack,
    output logic                     idle,
    output etfp_res_t                res
);

    localparam logic [PROD_W-1:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

    etfp_state_t state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;

    logic [COORD_BITS-1:0]    px_reg, px_next;
    logic [COORD_BITS-1:0]    py_reg, py_next;
    logic signed [Z_W-1:0]    c_re_reg, c_re_next;
    logic signed [Z_W-1:0]    c_im_reg, c_im_next;
    logic signed [Z_W-1:0]    zr_reg, zr_next;
    logic signed [Z_W-1:0]    zi_reg, zi_next;
    logic signed [PROD_W-1:0] r2_reg, r2_next;
    logic signed [PROD_W-1:0] diff_reg, diff_next;

    logic signed [Z_W-1:0]    op_a;
    logic signed [Z_W-1:0]    op_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [SUM_W-1:0] cre_sum;
    logic signed [SUM_W-1:0] cim_sum;
    logic signed [SUM_W-1:0] zr_sum;
    logic signed [SUM_W-1:0] zi_sum;
    logic [PROD_W-1:0]       mag_sq;
    logic                    escaped;

    etfp_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    assign cre_sum = SUM_W'(cfg.re_min) + SUM_W'(prod);
    assign cim_sum = SUM_W'(cfg.im_max) - SUM_W'(prod) - SUM_W'($signed({1'b0, cfg.scroll}));
    // The factor two of 2*zr*zi is taken by shifting one place less.
    assign zi_sum  = SUM_W'(prod >>> (FRAC_BITS - 1)) + SUM_W'(c_im_reg);
    assign zr_sum  = SUM_W'(diff_reg >>> FRAC_BITS) + SUM_W'(c_re_reg);
    // Both squares are non-negative and at most 2^62, so the sum cannot wrap.
    assign mag_sq  = $unsigned(r2_reg) + $unsigned(prod);
    assign escaped = mag_sq > ESC_LIMIT;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        c_re_next  = c_re_reg;
        c_im_next  = c_im_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        r2_next    = r2_reg;
        diff_next  = diff_reg;
        op_a       = zr_reg;
        op_b       = zr_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    state_next = ST_CRE;
                end
            end
            ST_CRE:
            begin
                op_a       = $signed(Z_W'(px_reg));
                op_b       = $signed({1'b0, cfg.re_step});
                state_next = ST_CIM;
            end
            ST_CIM:
            begin
                op_a       = $signed(Z_W'(py_reg));
                op_b       = $signed({1'b0, cfg.im_step});
                c_re_next  = sat_z(cre_sum);
                zr_next    = sat_z(cre_sum);
                state_next = ST_CIMW;
            end
            ST_CIMW:
            begin
                c_im_next = sat_z(cim_sum);
                zi_next   = sat_z(cim_sum);
                cnt_next  = '0;
                if (cfg.max_iter == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RR;
                end
            end
            ST_RR:
            begin
                op_a       = zr_reg;
                op_b       = zr_reg;
                state_next = ST_II;
            end
            ST_II:
            begin
                op_a       = zi_reg;
                op_b       = zi_reg;
                r2_next    = prod;
                state_next = ST_RI;
            end
            ST_RI:
            begin
                op_a      = zr_reg;
                op_b      = zi_reg;
                diff_next = r2_reg - prod;
                if (escaped)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                zr_next  = sat_z(zr_sum);
                zi_next  = sat_z(zi_sum);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == cfg.max_iter)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_RR;
                end
            end
            ST_DONE:
            begin
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        c_re_reg <= c_re_next;
        c_im_reg <= c_im_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        r2_reg   <= r2_next;
        diff_reg <= diff_next;
    end

    assign idle      = (state_reg == ST_IDLE);
    assign res.valid = (state_reg == ST_DONE);
    assign res.zi    = zi_reg;

endmodule

@@ rtl/escape_time_fractal_pixel_core.sv @@
// Escape-time fractal pixel core: one pixel coordinate in, one colour out.
// One pixel is in flight at a time; the next is taken once its result has moved into the
// output register, which happens only while that register is empty or being emptied.
// The shared multiplier (three products per iteration) serialises each iteration;
// rst_n (async, low) idles all.

module escape_time_fractal_pixel_core
    import etfp_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                   cfg_addr,
    input  logic [CFG_DAT_W-1:0]                   cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // pixel_x, pixel_y, zero padding to whole bytes
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // red, green, blue
    output logic [OUT_TDATA_W-1:0]                 m_tdata
);

    etfp_cfg_t cfg;
    etfp_res_t res;
    logic      idle;
    logic      res_ack;

    logic      out_valid_reg, out_valid_next;
    etfp_rgb_t rgb_reg;
    etfp_rgb_t rgb_next;

    logic [Z_W:0]         zi_mag;
    logic [Z_W:0]         ip_mag;
    logic [WHEEL_W-1:0]   wheel_in;

    etfp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    etfp_iter #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .start   (s_tvalid && s_tready),
        .pixel_x (s_tdata[COORD_BITS-1:0]),
        .pixel_y (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .res_ack (res_ack),
        .idle    (idle),
        .res     (res)
    );

    assign s_tready = idle;

    // Integer part of Z_im, truncated toward zero, taken on its magnitude.
    assign zi_mag   = res.zi[Z_W-1] ? ((Z_W+1)'(0) - {res.zi[Z_W-1], res.zi})
                                    : {res.zi[Z_W-1], res.zi};
    assign ip_mag   = zi_mag >> FRAC_BITS;
    assign wheel_in = res.zi[Z_W-1] ? WHEEL_W'(WHEEL_W'(0) - ip_mag[WHEEL_W-1:0])
                                    : ip_mag[WHEEL_W-1:0];

    // The result register loads a finished result whenever it is empty or being emptied.
    assign res_ack  = res.valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        rgb_next       = rgb_reg;
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            rgb_next       = wheel(wheel_in);
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rgb_reg <= rgb_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rgb_reg;

endmodule

@@ rtl/etfp_checker.sv @@
// Port-level assertions for the escape-time fractal pixel core, bound to its top level.
// Depends on etfp_pkg for the output data width.

module etfp_checker
    import etfp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [CHAN_W+1:0] chan_sum;
    logic              chan_zero;

    assign chan_sum  = {2'b00, m_tdata[CHAN_W-1:0]} + {2'b00, m_tdata[2*CHAN_W-1:CHAN_W]}
                     + {2'b00, m_tdata[3*CHAN_W-1:2*CHAN_W]};
    assign chan_zero = (m_tdata[CHAN_W-1:0] == '0) || (m_tdata[2*CHAN_W-1:CHAN_W] == '0)
                     || (m_tdata[3*CHAN_W-1:2*CHAN_W] == '0);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // Once a pixel is taken the core is busy for at least the next cycle.
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("core ready straight after taking a pixel");

    // A fresh result is only produced while the core was busy with a pixel.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a pixel in progress");

    // Every wheel colour has at least one dark channel and channels summing to full scale.
    a_wheel_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> chan_zero && (chan_sum == (CHAN_W+2)'(CHAN_FULL)))
        else $error("colour outside the wheel");

endmodule

bind escape_time_fractal_pixel_core etfp_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
